[rtl/modinv_pkg.sv]
// Shared types and constants for the modular inverse block.
// No dependencies; used by modular_inverse_ext_euclid_top.
package modinv_pkg;

  // Reset value of the modulus register
  localparam int MODULUS_RESET = 66;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINAL
  } state_t;

endpackage

[rtl/modular_inverse_ext_euclid_top.sv]
// Modular inverse by the extended Euclidean algorithm, top level.
// Depends on modinv_pkg and modinv_div.
//
// Usage:
//   Write the modulus through cfg_wen/cfg_wdata while the block is idle
//   (reset value 66). Each word on the s_ channel carries a value; the
//   block returns one word on the m_ channel with the inverse modulo the
//   modulus in m_tdata and the exists flag in m_tuser. When the gcd is not
//   one, inverse is zero and exists is clear.
// Operation:
//   Each Euclid step runs one check in ST_CHECK, VALUE_WIDTH divider
//   shifts and one coefficient update in ST_UPDATE. The steps repeat
//   until the next remainder is zero, so value zero runs no step; the
//   result then waits in ST_FINAL until the output register is free.
//   One item is in work at a time and s_tready is low meanwhile.
// Reset: synchronous; clears the sequencer and output valid, restores the
//   modulus to 66.
// Stall: a finished result sits in the output register; a new item can be
//   taken while it waits, and its result is held until the old one leaves.
module modular_inverse_ext_euclid_top #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_wen,
  input  logic [VALUE_WIDTH-1:0] cfg_wdata,    // modulus
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // [W-1:0] value, rest zero
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,  // [W-1:0] inverse, rest zero
  output logic                   m_tuser        // [0] exists
);

  localparam int W  = VALUE_WIDTH;
  localparam int DW = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int CW = VALUE_WIDTH + 2;

  modinv_pkg::state_t state, state_next;

  logic [W-1:0]         modulus;
  logic [W-1:0]         r, nr;
  logic signed [CW-1:0] t, nt;
  logic                 div_start;
  logic                 div_done;
  logic [W-1:0]         div_rem;
  logic signed [CW-1:0] div_prod;
  logic                 out_load;
  logic                 in_take;
  logic                 found;
  logic signed [CW-1:0] t_lift;
  logic [W-1:0]         inverse;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(modinv_pkg::MODULUS_RESET);
    end else if (cfg_wen) begin
      modulus <= cfg_wdata;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modinv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    in_take    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      modinv_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          in_take    = 1'b1;
          state_next = modinv_pkg::ST_CHECK;
        end
      end
      modinv_pkg::ST_CHECK: begin
        if (nr == '0) begin
          state_next = modinv_pkg::ST_FINAL;
        end else begin
          div_start  = 1'b1;
          state_next = modinv_pkg::ST_DIV;
        end
      end
      modinv_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = modinv_pkg::ST_UPDATE;
        end
      end
      modinv_pkg::ST_UPDATE: begin
        state_next = modinv_pkg::ST_CHECK;
      end
      modinv_pkg::ST_FINAL: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = modinv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = modinv_pkg::ST_IDLE;
      end
    endcase
  end

  // remainder and coefficient pairs
  always_ff @(posedge clk) begin
    if (in_take) begin
      r  <= modulus;
      nr <= s_tdata[W-1:0];
      t  <= '0;
      nt <= CW'(1);
    end else if (state == modinv_pkg::ST_UPDATE) begin
      r  <= nr;
      nr <= div_rem;
      t  <= nt;
      nt <= t - div_prod;
    end
  end

  // shared divider: r / nr, accumulating q * nt
  modinv_div #(
    .W  (W),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (r),
    .divisor  (nr),
    .coef     (nt),
    .done     (div_done),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  // final gcd check and lift of a negative coefficient
  assign found   = (r == W'(1));
  assign t_lift  = t[CW-1] ? (t + $signed({2'b00, modulus})) : t;
  assign inverse = found ? t_lift[W-1:0] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= DW'(inverse);
      m_tuser <= found;
    end
  end

endmodule

[rtl/modinv_div.sv]
// Shift-subtract divider, one quotient bit per cycle, that also accumulates
// quotient * coef so the caller can update its coefficient without a multiplier.
// Self-contained; instantiated by modular_inverse_ext_euclid_top.
module modinv_div #(
  parameter int W  = 16,
  parameter int CW = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  input  logic signed [CW-1:0] coef,
  output logic                 done,
  output logic [W-1:0]         rem,
  output logic signed [CW-1:0] prod
);

  localparam int CNTW = $clog2(W);

  logic              run;
  logic [CNTW-1:0]   cnt;
  logic [W-1:0]      quo_sh;
  logic [W-1:0]      divr;
  logic signed [CW-1:0] cf;
  logic [W:0]        ptry;
  logic [W:0]        pdiff;
  logic              ge;

  // trial subtract of the next partial remainder
  assign ptry  = {rem, quo_sh[W-1]};
  assign pdiff = ptry - {1'b0, divr};
  assign ge    = (ptry >= {1'b0, divr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(W - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder, dividend shifter, coefficient accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      quo_sh <= dividend;
      divr   <= divisor;
      cf     <= coef;
      prod   <= '0;
    end else if (run) begin
      rem    <= ge ? pdiff[W-1:0] : ptry[W-1:0];
      quo_sh <= {quo_sh[W-2:0], 1'b0};
      prod   <= (prod <<< 1) + (ge ? cf : CW'(0));
    end
  end

endmodule
